FILE: src/fis_pkg.sv
// ----------------------------------------------------------------------------
// fis_pkg: shared types and codes for the four input selector
// Process value types, lane result struct, configuration struct, select codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fis_pkg;

  localparam int NUM_LANES = 4;

  typedef logic signed [31:0] pv_t;
  typedef pv_t [NUM_LANES-1:0] pv_vec_t;

  // Operator select codes
  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_AUTO = 3'd0;
  localparam opcode_t OP_IN1  = 3'd1;
  localparam opcode_t OP_IN2  = 3'd2;
  localparam opcode_t OP_IN3  = 3'd3;
  localparam opcode_t OP_IN4  = 3'd4;

  // Selection type codes for automatic mode
  typedef logic [2:0] auto_mode_t;
  localparam auto_mode_t SEL_FIRST  = 3'd1;
  localparam auto_mode_t SEL_MIN    = 3'd2;
  localparam auto_mode_t SEL_MAX    = 3'd3;
  localparam auto_mode_t SEL_MIDDLE = 3'd4;
  localparam auto_mode_t SEL_AVG    = 3'd5;

  // Configuration register indexes
  localparam logic REG_AUTO_MODE = 1'b0;
  localparam logic REG_OOS       = 1'b1;

  localparam logic [2:0] IDX_MIDDLE = 3'd0;
  localparam logic [2:0] IDX_AVG    = 3'd4;

  typedef struct packed {
    logic [1:0] rank;       // stable sort position, ties broken by input number
    logic       max_first;  // first occurrence of the largest value
  } lane_info_t;

  typedef lane_info_t [NUM_LANES-1:0] lane_info_vec_t;

  typedef struct packed {
    auto_mode_t auto_mode;
    logic       oos;
  } fis_cfg_t;

endpackage

FILE: src/fis_lane.sv
// ----------------------------------------------------------------------------
// fis_lane: one compare lane
// Ranks its own input against the other three and flags first maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fis_lane import fis_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [1:0] lane_id,
  input  pv_vec_t    vals,
  output lane_info_t info_r
);

  pv_t        own;
  lane_info_t info_nxt;

  always_comb begin
    own = vals[lane_id];
    info_nxt.rank = 2'd0;
    info_nxt.max_first = 1'b1;
    for (int j = 0; j < NUM_LANES; j++) begin
      if (2'(j) != lane_id) begin
        // count lanes that sort ahead of this one
        if ((vals[j] < own) || ((vals[j] == own) && (2'(j) < lane_id))) begin
          info_nxt.rank = info_nxt.rank + 2'd1;
        end
        if (2'(j) < lane_id) begin
          if (!(own > vals[j])) begin
            info_nxt.max_first = 1'b0;
          end
        end else if (own < vals[j]) begin
          info_nxt.max_first = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info_r <= info_nxt;
    end
  end

endmodule

FILE: src/fis_merge.sv
// ----------------------------------------------------------------------------
// fis_merge: combine lane results
// Picks first, min, max, middle mean or average; applies the operator select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fis_merge import fis_pkg::*; (
  input  pv_vec_t        vals,
  input  opcode_t        opcode,
  input  lane_info_vec_t info,
  input  fis_cfg_t       cfg,
  input  pv_t            held_value,
  input  logic [2:0]     held_index,
  output pv_t            value_nxt,
  output logic [2:0]     index_nxt
);

  pv_t               min_val;
  pv_t               max_val;
  pv_t               mid_lo;
  pv_t               mid_hi;
  logic [2:0]        min_idx;
  logic [2:0]        max_idx;
  logic signed [32:0] mid_sum;
  logic signed [33:0] avg_sum;

  always_comb begin
    min_val = '0;
    max_val = '0;
    mid_lo  = '0;
    mid_hi  = '0;
    min_idx = 3'd1;
    max_idx = 3'd1;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (info[i].rank == 2'd0) begin
        min_val = vals[i];
        min_idx = {1'b0, 2'(i)} + 3'd1;
      end
      if (info[i].max_first) begin
        max_val = vals[i];
        max_idx = {1'b0, 2'(i)} + 3'd1;
      end
      if (info[i].rank == 2'd1) mid_lo = vals[i];
      if (info[i].rank == 2'd2) mid_hi = vals[i];
    end
  end

  assign mid_sum = 33'(mid_lo) + 33'(mid_hi);
  assign avg_sum = (34'(vals[0]) + 34'(vals[1])) + (34'(vals[2]) + 34'(vals[3]));

  always_comb begin
    value_nxt = held_value;
    index_nxt = held_index;
    if (!cfg.oos) begin
      case (opcode)
        OP_IN1: begin value_nxt = vals[0]; index_nxt = opcode; end
        OP_IN2: begin value_nxt = vals[1]; index_nxt = opcode; end
        OP_IN3: begin value_nxt = vals[2]; index_nxt = opcode; end
        OP_IN4: begin value_nxt = vals[3]; index_nxt = opcode; end
        OP_AUTO: begin
          case (cfg.auto_mode)
            SEL_FIRST:  begin value_nxt = vals[0]; index_nxt = 3'd1; end
            SEL_MIN:    begin value_nxt = min_val; index_nxt = min_idx; end
            SEL_MAX:    begin value_nxt = max_val; index_nxt = max_idx; end
            SEL_MIDDLE: begin value_nxt = mid_sum[32:1]; index_nxt = IDX_MIDDLE; end
            SEL_AVG:    begin value_nxt = avg_sum[33:2]; index_nxt = IDX_AVG; end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: src/four_input_selector.sv
// ----------------------------------------------------------------------------
// four_input_selector: process value selector over four Q16.16 inputs
// Path: accepted word -> stage 1 lane compare registers -> stage 2 held result register.
// Throughput: one word per cycle unless out_ready stalls a waiting result; the four
//   compare lanes and the merge adder each take a whole word at once.
// Reset: synchronous active low; clears valids, held value and index to zero,
//   selection type to first input, out of service to off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_input_selector import fis_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  pv_t         in_value_one,
  input  pv_t         in_value_two,
  input  pv_t         in_value_three,
  input  pv_t         in_value_four,
  input  opcode_t     in_opcode,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output pv_t         out_selected_value,
  output logic [2:0]  out_selected_index,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_wdata
);

  // Stage 1: lane compare registers; stage 2: held result, which is the output.
  logic           s1_valid_r;
  pv_vec_t        s1_vals_r;
  opcode_t        s1_opcode_r;
  lane_info_vec_t s1_info_r;
  logic           out_valid_r;
  pv_t            held_value_r;
  logic [2:0]     held_index_r;
  pv_t            held_value_nxt;
  logic [2:0]     held_index_nxt;
  fis_cfg_t       cfg_r;
  pv_vec_t        in_vals;
  logic           adv2;
  logic           ld2;

  assign in_vals = {in_value_four, in_value_three, in_value_two, in_value_one};

  // Advance the output slot when empty or drained; stage 1 moves whenever
  // its word can advance, so a new word enters an empty stage 1 while a result waits.
  assign adv2     = !out_valid_r || out_ready;
  assign ld2      = s1_valid_r && adv2;
  assign in_ready = !s1_valid_r || adv2;

  // Configuration: to be written only while the pipe is idle; the user is bound, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_mode <= SEL_FIRST;
      cfg_r.oos       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AUTO_MODE: cfg_r.auto_mode <= cfg_wdata;
        REG_OOS:       cfg_r.oos       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Stage 1 capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_vals_r   <= in_vals;
      s1_opcode_r <= in_opcode;
    end
  end

  // One compare lane per input; each finds its sort rank and max flag.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    fis_lane u_lane (
      .clk     (clk),
      .en      (in_ready),
      .lane_id (2'(g)),
      .vals    (in_vals),
      .info_r  (s1_info_r[g])
    );
  end

  // Merge lane results and update the held state.
  fis_merge u_merge (
    .vals       (s1_vals_r),
    .opcode     (s1_opcode_r),
    .info       (s1_info_r),
    .cfg        (cfg_r),
    .held_value (held_value_r),
    .held_index (held_index_r),
    .value_nxt  (held_value_nxt),
    .index_nxt  (held_index_nxt)
  );

  // Stage 2: the held state doubles as the output register; every word
  // reports it after its update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      held_value_r <= '0;
      held_index_r <= '0;
    end else begin
      if (adv2) begin
        out_valid_r <= s1_valid_r;
      end
      if (ld2) begin
        held_value_r <= held_value_nxt;
        held_index_r <= held_index_nxt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_selected_value = held_value_r;
  assign out_selected_index = held_index_r;

  // Lane ranks form a permutation: exactly one minimum lane.
  a_one_min: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot({s1_info_r[3].rank == 2'd0, s1_info_r[2].rank == 2'd0,
                            s1_info_r[1].rank == 2'd0, s1_info_r[0].rank == 2'd0}))
    else $error("lane ranks lost minimum uniqueness");

  a_one_max: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot({s1_info_r[3].max_first, s1_info_r[2].max_first,
                            s1_info_r[1].max_first, s1_info_r[0].max_first}))
    else $error("first maximum not unique");

  a_oos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ld2 && cfg_r.oos) |=> ($stable(held_value_r) && $stable(held_index_r)))
    else $error("held result changed while out of service");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_selected_index <= 3'd4))
    else $error("selected index out of range");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the four input selector
// Runs a table of directed words, then random words across configuration
// phases. Every accepted word advances a behavioral selector model; every result
// word is compared field by field, in order, with the model's or the row's prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import fis_pkg::*; ();

  // Codes the package leaves unnamed: the unused selects and selection types
  localparam opcode_t    OP_UNUSED5  = 3'd5;
  localparam opcode_t    OP_UNUSED6  = 3'd6;
  localparam opcode_t    OP_UNUSED7  = 3'd7;
  localparam auto_mode_t SEL_UNUSED0 = 3'd0;
  localparam auto_mode_t SEL_UNUSED6 = 3'd6;
  localparam auto_mode_t SEL_UNUSED7 = 3'd7;

  localparam pv_t PV_MAX = 32'sh7fff_ffff;
  localparam pv_t PV_MIN = 32'sh8000_0000;

  localparam int NUM_ROWS        = 25;
  localparam int NUM_PHASES      = 12;
  localparam int WORDS_PER_PHASE = 125;
  localparam int IDLE_PCT        = 23;
  localparam int SETTLE_CYCLES   = 6;
  localparam int CYCLE_LIMIT     = 200_000;

  typedef struct packed {
    pv_t        val;
    logic [2:0] idx;
  } result_t;

  // One directed word: the configuration it runs under, the payload, and an
  // optional hand-written result (otherwise the model supplies it)
  typedef struct packed {
    auto_mode_t st;
    logic       oos;
    pv_t        v1;
    pv_t        v2;
    pv_t        v3;
    pv_t        v4;
    opcode_t    op;
    logic       typed;
    pv_t        exp_val;
    logic [2:0] exp_idx;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  pv_t        in_value_one;
  pv_t        in_value_two;
  pv_t        in_value_three;
  pv_t        in_value_four;
  opcode_t    in_opcode;
  logic       out_valid;
  logic       out_ready = 1'b0;
  pv_t        out_selected_value;
  logic [2:0] out_selected_index;
  logic       cfg_we;
  logic       cfg_index;
  logic [2:0] cfg_wdata;

  // Selector model state and its copy of the configuration
  pv_t        held_pv;
  logic [2:0] held_idx;
  auto_mode_t cfg_sel;
  logic       cfg_oos;

  result_t    pending_results[$];
  stim_row_t  directed_rows[NUM_ROWS];
  int         error_count = 0;
  int         cycle_count = 0;
  bit         gaps_on;

  four_input_selector i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_value_one       (in_value_one),
    .in_value_two       (in_value_two),
    .in_value_three     (in_value_three),
    .in_value_four      (in_value_four),
    .in_opcode          (in_opcode),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_selected_value (out_selected_value),
    .out_selected_index (out_selected_index),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Advance the held value and index the way the selector does for one word
  task automatic select_word(input pv_t a, input pv_t b, input pv_t c, input pv_t d,
                             input opcode_t op);
    longint lane[4];
    longint t;
    int     best;
    lane[0] = a;
    lane[1] = b;
    lane[2] = c;
    lane[3] = d;
    best    = 0;
    // Out of service or an unused select: keep the held word untouched
    if (cfg_oos) return;
    if (op >= OP_IN1 && op <= OP_IN4) begin
      held_pv  = pv_t'(lane[op - 1]);
      held_idx = op;
    end else if (op == OP_AUTO) begin
      case (cfg_sel)
        SEL_FIRST: begin
          held_pv  = a;
          held_idx = 3'd1;
        end
        SEL_MIN, SEL_MAX: begin
          // Strict compare keeps the lowest-numbered input on ties
          for (int i = 1; i < 4; i++) begin
            if (cfg_sel == SEL_MIN ? lane[i] < lane[best] : lane[i] > lane[best]) begin
              best = i;
            end
          end
          held_pv  = pv_t'(lane[best]);
          held_idx = 3'(best + 1);
        end
        SEL_MIDDLE: begin
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3 - i; j++) begin
              if (lane[j] > lane[j+1]) begin
                t         = lane[j];
                lane[j]   = lane[j+1];
                lane[j+1] = t;
              end
            end
          end
          // Arithmetic shift floors toward minus infinity
          held_pv  = pv_t'((lane[1] + lane[2]) >>> 1);
          held_idx = IDX_MIDDLE;
        end
        SEL_AVG: begin
          held_pv  = pv_t'((lane[0] + lane[1] + lane[2] + lane[3]) >>> 2);
          held_idx = IDX_AVG;
        end
        default: ;
      endcase
    end
  endtask

  // Offer one word, idling at random first; return at the accepting edge.
  // Call at a rising edge only.
  task automatic push_word(input pv_t a, input pv_t b, input pv_t c, input pv_t d,
                           input opcode_t op, input logic typed, input pv_t ev,
                           input logic [2:0] ei);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value_one   <= a;
    in_value_two   <= b;
    in_value_three <= c;
    in_value_four  <= d;
    in_opcode      <= op;
    // Hold the word until ready is seen high at an edge
    do @(posedge clk); while (!in_ready);
    select_word(a, b, c, d, op);
    pending_results.push_back(typed ? result_t'{ev, ei} : result_t'{held_pv, held_idx});
  endtask

  // Drop valid and wait until every predicted result word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; the block must be idle
  task automatic write_config(input auto_mode_t st, input logic oos);
    cfg_we    <= 1'b1;
    cfg_index <= REG_AUTO_MODE;
    cfg_wdata <= st;
    @(posedge clk);
    cfg_index <= REG_OOS;
    cfg_wdata <= {2'b00, oos};
    @(posedge clk);
    cfg_we  <= 1'b0;
    cfg_sel = st;
    cfg_oos = oos;
  endtask

  // Mix of extremes, small values near zero and full-range random values
  function automatic pv_t rand_pv();
    case ($urandom_range(7))
      0:       return PV_MAX;
      1:       return PV_MIN;
      2:       return pv_t'(int'($urandom_range(20)) - 10);
      default: return pv_t'($urandom);
    endcase
  endfunction

  task automatic push_random_word();
    pv_t     v[4];
    opcode_t op;
    int      pick;
    for (int i = 0; i < 4; i++) v[i] = rand_pv();
    // Force ties now and then so first-occurrence ordering gets exercised
    if ($urandom_range(3) == 0) v[$urandom_range(3)] = v[$urandom_range(3)];
    pick = $urandom_range(99);
    if (pick < 50)      op = OP_AUTO;
    else if (pick < 90) op = opcode_t'($urandom_range(OP_IN4, OP_IN1));
    else                op = opcode_t'($urandom_range(OP_UNUSED7, OP_UNUSED5));
    push_word(v[0], v[1], v[2], v[3], op, 1'b0, '0, '0);
  endtask

  // Stall the result side at random while gaps are enabled
  always @(posedge clk) begin
    out_ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
  end

  // Score each result word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", out_selected_value, {29'd0, out_selected_index});
      end else begin
        result_t want;
        want = pending_results.pop_front();
        if (out_selected_value !== want.val) begin
          report_mismatch("selected_value", out_selected_value, want.val);
        end
        if (out_selected_index !== want.idx) begin
          report_mismatch("selected_index", {29'd0, out_selected_index}, {29'd0, want.idx});
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_value_one   = '0;
    in_value_two   = '0;
    in_value_three = '0;
    in_value_four  = '0;
    in_opcode      = OP_AUTO;
    cfg_we         = 1'b0;
    cfg_index      = REG_AUTO_MODE;
    cfg_wdata      = '0;
    gaps_on        = 1'b1;
    // Reset values of the model
    held_pv        = '0;
    held_idx       = '0;
    cfg_sel        = SEL_FIRST;
    cfg_oos        = 1'b0;

    // st, oos, inputs 1..4, select, typed, value, index
    directed_rows = '{
      // Reset state comes straight through on an unused select
      '{SEL_FIRST,   1'b0, 1, 2, 3, 4,                 OP_UNUSED5, 1'b1, 0,      3'd0},
      '{SEL_FIRST,   1'b0, PV_MAX, PV_MIN, 1, -1,      OP_AUTO,    1'b1, PV_MAX, 3'd1},
      '{SEL_FIRST,   1'b0, PV_MAX, PV_MIN, 1, -1,      OP_IN2,     1'b1, PV_MIN, 3'd2},
      '{SEL_FIRST,   1'b0, 5, 6, -7, 8,                OP_IN3,     1'b1, -7,     3'd3},
      '{SEL_FIRST,   1'b0, 5, 6, -7, PV_MIN,           OP_IN4,     1'b1, PV_MIN, 3'd4},
      '{SEL_FIRST,   1'b0, 9, 9, 9, 9,                 OP_UNUSED7, 1'b1, PV_MIN, 3'd4},
      // Ties report the first input holding the extreme
      '{SEL_MIN,     1'b0, 5, -3, -3, 7,               OP_AUTO,    1'b1, -3,     3'd2},
      '{SEL_MIN,     1'b0, PV_MIN, PV_MIN, PV_MIN, PV_MIN, OP_AUTO, 1'b1, PV_MIN, 3'd1},
      '{SEL_MIN,     1'b0, PV_MAX, PV_MAX, 0, PV_MIN,  OP_UNUSED6, 1'b1, PV_MIN, 3'd1},
      '{SEL_MAX,     1'b0, PV_MAX, 0, PV_MAX, PV_MAX,  OP_AUTO,    1'b1, PV_MAX, 3'd1},
      '{SEL_MAX,     1'b0, PV_MIN, -1, -1, -5,         OP_AUTO,    1'b1, -1,     3'd2},
      '{SEL_MIDDLE,  1'b0, PV_MAX, PV_MAX, PV_MAX, PV_MAX, OP_AUTO, 1'b1, PV_MAX, IDX_MIDDLE},
      '{SEL_MIDDLE,  1'b0, PV_MIN, PV_MIN, PV_MIN, PV_MIN, OP_AUTO, 1'b1, PV_MIN, IDX_MIDDLE},
      // Odd negative middle sum rounds down
      '{SEL_MIDDLE,  1'b0, 0, -1, -10, 10,             OP_AUTO,    1'b0, 0,      3'd0},
      '{SEL_MIDDLE,  1'b0, PV_MAX, PV_MIN, PV_MAX, PV_MIN, OP_AUTO, 1'b0, 0,      3'd0},
      '{SEL_AVG,     1'b0, PV_MAX, PV_MAX, PV_MAX, PV_MAX, OP_AUTO, 1'b1, PV_MAX, IDX_AVG},
      '{SEL_AVG,     1'b0, PV_MIN, PV_MIN, PV_MIN, PV_MIN, OP_AUTO, 1'b1, PV_MIN, IDX_AVG},
      '{SEL_AVG,     1'b0, -1, 0, 0, 0,                OP_AUTO,    1'b0, 0,      3'd0},
      // Unused selection types hold in automatic but not under a forced select
      '{SEL_UNUSED0, 1'b0, 1, 2, 3, 4,                 OP_AUTO,    1'b0, 0,      3'd0},
      '{SEL_UNUSED0, 1'b0, 1, 2, 3, 4,                 OP_IN1,     1'b1, 1,      3'd1},
      '{SEL_UNUSED6, 1'b0, 7, 7, 7, 7,                 OP_AUTO,    1'b0, 0,      3'd0},
      '{SEL_UNUSED7, 1'b0, 7, 7, 7, 7,                 OP_AUTO,    1'b0, 0,      3'd0},
      // Out of service freezes the held word
      '{SEL_FIRST,   1'b1, 3, 3, 3, 3,                 OP_IN2,     1'b0, 0,      3'd0},
      '{SEL_FIRST,   1'b1, PV_MAX, 0, 0, 0,            OP_AUTO,    1'b0, 0,      3'd0},
      '{SEL_FIRST,   1'b0, -5, 0, 0, 0,                OP_AUTO,    1'b1, -5,     3'd1}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; reconfigure only once the pipe has emptied
    foreach (directed_rows[r]) begin
      if (directed_rows[r].st != cfg_sel || directed_rows[r].oos != cfg_oos) begin
        drain_results();
        write_config(directed_rows[r].st, directed_rows[r].oos);
      end
      push_word(directed_rows[r].v1, directed_rows[r].v2, directed_rows[r].v3,
                directed_rows[r].v4, directed_rows[r].op, directed_rows[r].typed,
                directed_rows[r].exp_val, directed_rows[r].exp_idx);
    end

    // Random phases: walk every selection type first, then pick at random.
    // Two phases run with no gaps on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_config(p < 8 ? auto_mode_t'(p) : auto_mode_t'($urandom_range(7)),
                   (p == 3 || p == 9 || $urandom_range(7) == 0));
      gaps_on = !(p == 5 || p == 6);
      repeat (WORDS_PER_PHASE) push_random_word();
    end

    gaps_on = 1'b1;
    drain_results();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
